// File: src/taf_pkg.sv
package taf_pkg;

   localparam int CNT_W   = 16;
   localparam int OFF_W   = 16;
   localparam int HALF_W  = 16;
   localparam int LEVEL_W = 10;
   localparam int PULSE_W = 8;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 16;

   // wide enough to hold level + offset + half period before wrapping
   localparam int SUM_W = CNT_W + OFF_W + 2;

   localparam logic [OFF_W-1:0]   RST_FIRE_OFFSET   = OFF_W'(150);
   localparam logic [HALF_W-1:0]  RST_HALF_PERIOD   = HALF_W'(1250);
   localparam logic [LEVEL_W-1:0] RST_FULL_ON_BELOW = LEVEL_W'(64);
   localparam logic [PULSE_W-1:0] RST_PULSE_TICKS   = PULSE_W'(1);
   localparam logic [CNT_W-1:0]   RST_FIRE_POINT    = CNT_W'(100);
   localparam logic [CNT_W-1:0]   FIRE_PARKED       = {CNT_W{1'b1}};

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_FIRE_OFFSET   = 2'd0,
      CSR_HALF_PERIOD   = 2'd1,
      CSR_FULL_ON_BELOW = 2'd2,
      CSR_PULSE_TICKS   = 2'd3
   } csr_idx_type;

   typedef struct packed {
      logic [OFF_W-1:0]   fire_offset;
      logic [HALF_W-1:0]  half_period;
      logic [LEVEL_W-1:0] full_on_below;
      logic [PULSE_W-1:0] pulse_ticks;
   } csr_type;

   typedef struct packed {
      logic gate;
      logic fired;
   } result_type;

endpackage

// File: src/taf_csr.sv
module taf_csr
   import taf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data,
   output csr_type               cfg
);

   csr_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write) begin
         case (csr_idx_type'(csr_index))
            CSR_FIRE_OFFSET:   cfg_in.fire_offset   = csr_data[OFF_W-1:0];
            CSR_HALF_PERIOD:   cfg_in.half_period   = csr_data[HALF_W-1:0];
            CSR_FULL_ON_BELOW: cfg_in.full_on_below = csr_data[LEVEL_W-1:0];
            CSR_PULSE_TICKS:   cfg_in.pulse_ticks   = csr_data[PULSE_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.fire_offset   <= RST_FIRE_OFFSET;
         cfg_ff.half_period   <= RST_HALF_PERIOD;
         cfg_ff.full_on_below <= RST_FULL_ON_BELOW;
         cfg_ff.pulse_ticks   <= RST_PULSE_TICKS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// File: src/taf_core.sv
module taf_core
   import taf_pkg::*;
(
   input  logic               clock,
   input  logic               reset,
   input  csr_type            cfg,
   input  logic               tick,
   input  logic               zero_cross,
   input  logic [LEVEL_W-1:0] phase_delay,
   output result_type         result
);

   logic [CNT_W-1:0]   tick_count_ff, tick_count_in;
   logic [CNT_W-1:0]   fire_point_ff, fire_point_in;
   logic               held_on_ff, held_on_in;
   logic [PULSE_W-1:0] pulse_left_ff, pulse_left_in;

   logic [PULSE_W-1:0] pulse_now;
   logic [SUM_W-1:0]   first_sum;
   logic [SUM_W-1:0]   rearm_sum;
   logic [CNT_W-1:0]   count_next;
   logic               match;

   assign first_sum  = SUM_W'(phase_delay) + SUM_W'(cfg.fire_offset);
   assign rearm_sum  = first_sum + SUM_W'(cfg.half_period);
   assign count_next = tick_count_ff + CNT_W'(1);
   assign match      = !zero_cross && (count_next == fire_point_ff);

   always_comb begin
      tick_count_in = tick_count_ff;
      fire_point_in = fire_point_ff;
      held_on_in    = held_on_ff;
      pulse_now     = pulse_left_ff;
      if (zero_cross) begin
         // crossing cancels any pulse; no compare in this tick
         tick_count_in = '0;
         pulse_now     = '0;
         if (phase_delay < cfg.full_on_below) begin
            held_on_in    = 1'b1;
            fire_point_in = FIRE_PARKED;
         end else begin
            held_on_in    = 1'b0;
            fire_point_in = first_sum[CNT_W-1:0];
         end
      end else begin
         tick_count_in = count_next;
         if (match) begin
            held_on_in    = 1'b0;
            pulse_now     = (cfg.pulse_ticks != '0) ? cfg.pulse_ticks : PULSE_W'(1);
            fire_point_in = rearm_sum[CNT_W-1:0];
         end
      end
      result.gate   = held_on_in || (pulse_now != '0);
      result.fired  = match;
      pulse_left_in = (pulse_now != '0) ? pulse_now - PULSE_W'(1) : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tick_count_ff <= '0;
         fire_point_ff <= RST_FIRE_POINT;
         held_on_ff    <= 1'b0;
         pulse_left_ff <= '0;
      end else if (tick) begin
         tick_count_ff <= tick_count_in;
         fire_point_ff <= fire_point_in;
         held_on_ff    <= held_on_in;
         pulse_left_ff <= pulse_left_in;
      end
   end

endmodule

// File: src/taf_out.sv
module taf_out
   import taf_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       load,
   input  result_type result,
   output logic       full_stalled,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   output logic       rsp_gate,
   output logic       rsp_fired
);

   logic       valid_ff, valid_in;
   result_type data_ff;

   // register can take a new result unless it holds one that is stalled
   assign full_stalled = valid_ff && rsp_stall;

   always_comb begin
      valid_in = valid_ff;
      if (load) begin
         valid_in = 1'b1;
      end else if (!rsp_stall) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load) begin
         data_ff <= result;
      end
   end

   assign rsp_valid = valid_ff;
   assign rsp_gate  = data_ff.gate;
   assign rsp_fired = data_ff.fired;

endmodule

// File: src/triac_phase_angle_firing_unit.sv
// channel | direction | ports                                            | transfer
// req     | in        | req_valid req_stall req_zero_cross req_phase_delay | valid && !stall
// rsp     | out       | rsp_valid rsp_stall rsp_gate rsp_fired           | valid && !stall
// csr     | in        | csr_write csr_index csr_data                     | csr_write
//
// One tick per cycle while req_stall is low; its result shows in the output register in the next cycle.
// Timer state is updated in the transfer cycle, so ticks may follow back to back.
// req_stall is high only while the output register holds a result and rsp_stall is high.
// Synchronous reset restores the register defaults and clears counter and pulse state.
module triac_phase_angle_firing_unit
   import taf_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_zero_cross,
   input  logic [LEVEL_W-1:0]    req_phase_delay,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_gate,
   output logic                  rsp_fired,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_data
);

   csr_type    cfg;
   result_type result;
   logic       tick;
   logic       full_stalled;

   assign req_stall = full_stalled;
   assign tick      = req_valid && !full_stalled;

   taf_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_data  (csr_data),
      .cfg       (cfg)
   );

   taf_core u_core (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg),
      .tick        (tick),
      .zero_cross  (req_zero_cross),
      .phase_delay (req_phase_delay),
      .result      (result)
   );

   taf_out u_out (
      .clock        (clock),
      .reset        (reset),
      .load         (tick),
      .result       (result),
      .full_stalled (full_stalled),
      .rsp_valid    (rsp_valid),
      .rsp_stall    (rsp_stall),
      .rsp_gate     (rsp_gate),
      .rsp_fired    (rsp_fired)
   );

endmodule

// File: src/taf_checker.sv
module taf_checker
   import taf_pkg::*;
(
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_stall,
   input logic req_zero_cross,
   input logic rsp_valid,
   input logic rsp_stall,
   input logic rsp_gate,
   input logic rsp_fired
);

   // stalled result holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp_gate) && $stable(rsp_fired))
      else $error("stalled result changed");

   // every accepted tick gives a result next cycle
   a_one_result: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> rsp_valid)
      else $error("accepted tick produced no result");

   // a zero-crossing tick never fires
   a_zc_no_fire: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall && req_zero_cross |=> !rsp_fired)
      else $error("fired on zero-crossing tick");

   // a firing starts a pulse, so the gate is on in that tick
   a_fire_gate: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_fired |-> rsp_gate)
      else $error("fired without gate");

endmodule

bind triac_phase_angle_firing_unit taf_checker u_taf_checker (.*);

// File: tb/triac_phase_angle_firing_unit_tb.sv
`timescale 1ns / 1ps

module triac_phase_angle_firing_unit_tb;
   import taf_pkg::*;

   typedef enum logic {ROW_TICK, ROW_CSR} row_kind_type;

   typedef struct packed {
      row_kind_type          kind;
      logic                  zc;
      logic [LEVEL_W-1:0]    lvl;
      csr_idx_type           idx;
      logic [CSR_DATA_W-1:0] data;
      logic                  typed;
      logic                  want_gate;
      logic                  want_fired;
   } plan_row_type;

   localparam int PLAN_LEN = 29;

   logic                  clock = 1'b0;
   logic                  reset = 1'b1;
   logic                  req_valid = 1'b0;
   logic                  req_stall;
   logic                  req_zero_cross = 1'b0;
   logic [LEVEL_W-1:0]    req_phase_delay = '0;
   logic                  rsp_valid;
   logic                  rsp_stall = 1'b0;
   logic                  rsp_gate;
   logic                  rsp_fired;
   logic                  csr_write = 1'b0;
   csr_idx_type           csr_index = CSR_FIRE_OFFSET;
   logic [CSR_DATA_W-1:0] csr_data = '0;

   // timer state as the block should hold it
   csr_type            csr_shadow;
   logic [CNT_W-1:0]   tick_cnt;
   logic [CNT_W-1:0]   arm_point;
   logic               gate_held;
   logic [PULSE_W-1:0] pulse_rem;

   result_type   gate_due_q[$];
   int           mismatch_cnt = 0;
   int           send_idle_pct = 0;
   int           recv_idle_pct = 0;
   int           ticks_sent = 0;
   bit           hold_req = 1'b0;
   int           hold_left = 0;
   plan_row_type plan [PLAN_LEN];

   triac_phase_angle_firing_unit dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_zero_cross  (req_zero_cross),
      .req_phase_delay (req_phase_delay),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_gate        (rsp_gate),
      .rsp_fired       (rsp_fired),
      .csr_write       (csr_write),
      .csr_index       (csr_index),
      .csr_data        (csr_data)
   );

   initial begin
      forever #4 clock = ~clock;
   end

   initial begin
      #4_000_000;
      $display("FAILED: results differ");
      $finish;
   end

   function automatic result_type advance_timer(input logic zc, input logic [LEVEL_W-1:0] lvl);
      result_type res;
      res = '0;
      if (zc) begin
         tick_cnt  = '0;
         pulse_rem = '0;
         if (lvl < csr_shadow.full_on_below) begin
            gate_held = 1'b1;
            arm_point = FIRE_PARKED;
         end else begin
            gate_held = 1'b0;
            arm_point = CNT_W'(lvl + csr_shadow.fire_offset);
         end
      end else begin
         tick_cnt = tick_cnt + 1'b1;
         if (tick_cnt == arm_point) begin
            res.fired = 1'b1;
            // a match ends any held-on state
            gate_held = 1'b0;
            pulse_rem = (csr_shadow.pulse_ticks == '0) ? PULSE_W'(1) : csr_shadow.pulse_ticks;
            arm_point = CNT_W'(csr_shadow.half_period + lvl + csr_shadow.fire_offset);
         end
      end
      res.gate = gate_held || (pulse_rem != '0);
      if (pulse_rem != '0)
         pulse_rem = pulse_rem - 1'b1;
      return res;
   endfunction

   task automatic send_tick(input logic zc, input logic [LEVEL_W-1:0] lvl);
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid       <= 1'b1;
      req_zero_cross  <= zc;
      req_phase_delay <= lvl;
      do @(posedge clock); while (req_stall);
      gate_due_q.push_back(advance_timer(zc, lvl));
      ticks_sent++;
   endtask

   task automatic quiesce();
      req_valid <= 1'b0;
      while (gate_due_q.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_reg(input csr_idx_type idx, input logic [CSR_DATA_W-1:0] val);
      csr_write <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      @(posedge clock);
      csr_write <= 1'b0;
      case (idx)
         CSR_FIRE_OFFSET:   csr_shadow.fire_offset   = val;
         CSR_HALF_PERIOD:   csr_shadow.half_period   = val;
         CSR_FULL_ON_BELOW: csr_shadow.full_on_below = val[LEVEL_W-1:0];
         CSR_PULSE_TICKS:   csr_shadow.pulse_ticks   = val[PULSE_W-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // result side: check each transfer, then pick the next stall
   initial begin
      result_type want;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall) begin
            if (gate_due_q.size() == 0) begin
               mismatch_cnt++;
               if (mismatch_cnt <= 10)
                  $display("unexpected transfer: gate %0b fired %0b", rsp_gate, rsp_fired);
            end else begin
               want = gate_due_q.pop_front();
               if (rsp_gate !== want.gate || rsp_fired !== want.fired) begin
                  mismatch_cnt++;
                  if (mismatch_cnt <= 10)
                     $display("mismatch: gate exp %0b got %0b, fired exp %0b got %0b",
                              want.gate, rsp_gate, want.fired, rsp_fired);
               end
            end
         end
         if (hold_req) begin
            hold_req  = 1'b0;
            hold_left = 300;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < recv_idle_pct);
         end
      end
   end

   initial begin
      int           phase;
      int           stop_at;
      int           lvl;
      int           run_len;
      int           pick;
      bit           hold_done;
      bit           pause_done;
      plan_row_type row;

      csr_shadow = '{RST_FIRE_OFFSET, RST_HALF_PERIOD, RST_FULL_ON_BELOW, RST_PULSE_TICKS};
      tick_cnt   = '0;
      arm_point  = RST_FIRE_POINT;
      gate_held  = 1'b0;
      pulse_rem  = '0;
      hold_done  = 1'b0;
      pause_done = 1'b0;

      plan = '{
         // reset defaults: offset 150, full on below 64
         '{ROW_TICK, 1'b0, 10'd0,    CSR_FIRE_OFFSET,   16'h0000, 1'b1, 1'b0, 1'b0},
         '{ROW_TICK, 1'b1, 10'd63,   CSR_FIRE_OFFSET,   16'h0000, 1'b1, 1'b1, 1'b0},
         '{ROW_TICK, 1'b0, 10'd1020, CSR_FIRE_OFFSET,   16'h0000, 1'b1, 1'b1, 1'b0},
         '{ROW_TICK, 1'b1, 10'd64,   CSR_FIRE_OFFSET,   16'h0000, 1'b1, 1'b0, 1'b0},
         '{ROW_TICK, 1'b1, 10'd1023, CSR_FIRE_OFFSET,   16'h0000, 1'b1, 1'b0, 1'b0},
         '{ROW_CSR,  1'b0, 10'd0,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_CSR,  1'b0, 10'd0,    CSR_HALF_PERIOD,   16'd3,    1'b0, 1'b0, 1'b0},
         '{ROW_CSR,  1'b0, 10'd0,    CSR_FULL_ON_BELOW, 16'h0000, 1'b0, 1'b0, 1'b0},
         // zero width must act as one tick
         '{ROW_CSR,  1'b0, 10'd0,    CSR_PULSE_TICKS,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b1, 10'd2,    CSR_FIRE_OFFSET,   16'h0000, 1'b1, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd2,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd2,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd2,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd2,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd2,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         // wide data, only the low byte lands
         '{ROW_CSR,  1'b0, 10'd0,    CSR_PULSE_TICKS,   16'hFFFF, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b1, 10'd1,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd1,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd1,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         // zero crossing cuts the running pulse
         '{ROW_TICK, 1'b1, 10'd1,    CSR_FIRE_OFFSET,   16'h0000, 1'b1, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd1,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_CSR,  1'b0, 10'd0,    CSR_FULL_ON_BELOW, 16'hFFFF, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b1, 10'd1020, CSR_FIRE_OFFSET,   16'h0000, 1'b1, 1'b1, 1'b0},
         '{ROW_CSR,  1'b0, 10'd0,    CSR_FULL_ON_BELOW, 16'h0000, 1'b0, 1'b0, 1'b0},
         // sums wrap at the counter width
         '{ROW_CSR,  1'b0, 10'd0,    CSR_FIRE_OFFSET,   16'hFFFF, 1'b0, 1'b0, 1'b0},
         '{ROW_CSR,  1'b0, 10'd0,    CSR_HALF_PERIOD,   16'hFFFF, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b1, 10'd3,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd3,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0},
         '{ROW_TICK, 1'b0, 10'd3,    CSR_FIRE_OFFSET,   16'h0000, 1'b0, 1'b0, 1'b0}
      };

      repeat (9) @(posedge clock);
      reset <= 1'b0;

      foreach (plan[i]) begin
         row = plan[i];
         if (row.kind == ROW_CSR) begin
            quiesce();
            write_reg(row.idx, row.data);
         end else begin
            send_tick(row.zc, row.lvl);
            // hand-written answer replaces the computed one for this transfer
            if (row.typed)
               gate_due_q[gate_due_q.size()-1] = '{gate: row.want_gate, fired: row.want_fired};
         end
      end

      for (phase = 0; phase < 6; phase++) begin
         quiesce();
         send_idle_pct = (phase < 2) ? 30 : (phase < 4) ? 53 : 0;
         recv_idle_pct = (phase < 2) ? 53 : (phase < 4) ? 30 : 0;

         pick = $urandom_range(0, 19);
         write_reg(CSR_FIRE_OFFSET,
                   (pick < 10) ? 16'($urandom_range(0, 40)) :
                   (pick < 13) ? 16'h0000 :
                   (pick < 16) ? 16'(16'hFFFF - $urandom_range(0, 20)) : 16'($urandom));
         pick = $urandom_range(0, 19);
         write_reg(CSR_HALF_PERIOD,
                   (pick < 10) ? 16'($urandom_range(1, 60)) :
                   (pick < 13) ? 16'h0000 :
                   (pick < 16) ? 16'hFFFF : 16'($urandom));
         pick = $urandom_range(0, 19);
         write_reg(CSR_FULL_ON_BELOW,
                   (pick < 10) ? 16'($urandom_range(0, 80)) :
                   (pick < 13) ? 16'h0000 :
                   (pick < 16) ? 16'h03FF : 16'($urandom));
         pick = $urandom_range(0, 19);
         write_reg(CSR_PULSE_TICKS,
                   (pick < 10) ? 16'($urandom_range(1, 8)) :
                   (pick < 13) ? 16'h0000 :
                   (pick < 16) ? 16'h00FF : 16'($urandom));

         stop_at = ticks_sent + 100;
         while (ticks_sent < stop_at) begin
            if (phase == 0 && !hold_done && ticks_sent >= stop_at - 60) begin
               hold_req  = 1'b1;
               hold_done = 1'b1;
            end
            if (phase == 3 && !pause_done && ticks_sent >= stop_at - 50) begin
               quiesce();
               pause_done = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0) begin
               // noise: zero crossings at random, any level
               repeat ($urandom_range(1, 6))
                  send_tick(1'($urandom_range(0, 1)), LEVEL_W'($urandom_range(0, 1023)));
            end else begin
               // one half cycle: crossing, then ticks, usually past the firing point
               lvl = (pick < 3) ? $urandom_range(0, 1023) : $urandom_range(0, 60);
               send_tick(1'b1, LEVEL_W'(lvl));
               run_len = (lvl + csr_shadow.fire_offset) % 65536;
               if (run_len <= 400 && pick != 9)
                  run_len += $urandom_range(0, 60);
               else
                  run_len = $urandom_range(0, 30);
               // keep each phase near its share of ticks
               if (run_len > stop_at - ticks_sent)
                  run_len = stop_at - ticks_sent;
               repeat (run_len)
                  send_tick(1'b0, ($urandom_range(0, 9) == 0) ?
                                  LEVEL_W'($urandom_range(0, 1023)) : LEVEL_W'(lvl));
            end
         end
      end

      quiesce();
      if (mismatch_cnt == 0 && gate_due_q.size() == 0)
         $display("PASSED: all results match");
      else
         $display("FAILED: results differ");
      $finish;
   end

endmodule

// File: filelist.f
src/taf_pkg.sv
src/taf_csr.sv
src/taf_core.sv
src/taf_out.sv
src/triac_phase_angle_firing_unit.sv
src/taf_checker.sv
tb/triac_phase_angle_firing_unit_tb.sv
